// ===== rtl/pwtc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwtc_pkg
// Shared types and constants for the compact-target proof-of-work checker.
// ----------------------------------------------------------------------------
package pwtc_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned TargetW  = 256;
  localparam int unsigned CompactW = 32;
  localparam int unsigned MantW    = 23;
  localparam int unsigned ExpoW    = 8;
  localparam int unsigned ByteShW  = 5;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] REG_LIMIT_WORD0 = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_WORD1 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_WORD2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_WORD3 = 2'd3;

  localparam logic [WordW-1:0] LIMIT_WORD0_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WordW-1:0] LIMIT_WORD1_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WordW-1:0] LIMIT_WORD2_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WordW-1:0] LIMIT_WORD3_RST = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_PASS    = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_ABOVE   = 2'd2
  } status_e;

  typedef struct packed {
    logic [WordW-1:0]    hash_word0;
    logic [WordW-1:0]    hash_word1;
    logic [WordW-1:0]    hash_word2;
    logic [WordW-1:0]    hash_word3;
    logic [CompactW-1:0] compact_bits;
  } pwtc_in_t;

  typedef struct packed {
    status_e status;
    logic    negative_flag;
    logic    overflow_flag;
  } pwtc_out_t;

  // decode stage to shift stage
  typedef struct packed {
    logic               valid;
    logic               negative;
    logic               overflow;
    logic               kill;
    logic [ByteShW-1:0] byte_shift;
  } pwtc_ctl_t;

  // shift stage to compare stage
  typedef struct packed {
    logic valid;
    logic negative;
    logic overflow;
  } pwtc_stat_t;

endpackage

// ===== rtl/pwtc_decode.sv =====
// ----------------------------------------------------------------------------
// pwtc_decode
// Stage 1: split the compact word, pre-shift small exponents, raise flags.
// ----------------------------------------------------------------------------
module pwtc_decode
  import pwtc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  pwtc_in_t             item_i,
  output pwtc_ctl_t            ctl_o,
  output logic [MantW-1:0]     mant_o,
  output logic [TargetW-1:0]   hash_o
);

  logic [ExpoW-1:0]   expo;
  logic [MantW-1:0]   mant_raw;
  logic [MantW-1:0]   mant_d;
  logic [ExpoW-1:0]   shift_full;
  logic               kill_d;
  logic [ByteShW-1:0] byte_shift_d;
  logic               mant_nz;
  logic               neg_d;
  logic               ovf_d;

  logic               valid_q;
  logic               neg_q;
  logic               ovf_q;
  logic               kill_q;
  logic [ByteShW-1:0] byte_shift_q;
  logic [MantW-1:0]   mant_q;
  logic [TargetW-1:0] hash_q;

  always_comb begin
    expo         = item_i.compact_bits[31:24];
    mant_raw     = item_i.compact_bits[MantW-1:0];
    shift_full   = expo - 8'd3;
    mant_d       = mant_raw;
    kill_d       = 1'b0;
    byte_shift_d = '0;
    if (expo[7:2] == 6'd0) begin
      case (expo[1:0])
        2'd0:    mant_d = '0;
        2'd1:    mant_d = mant_raw >> 16;
        2'd2:    mant_d = mant_raw >> 8;
        default: mant_d = mant_raw;
      endcase
    end else begin
      kill_d       = (shift_full[7:5] != 3'd0);
      byte_shift_d = shift_full[ByteShW-1:0];
    end
    mant_nz = (mant_d != '0);
    neg_d   = mant_nz && item_i.compact_bits[23];
    ovf_d   = mant_nz && ((expo > 8'd34) ||
                          ((mant_d > 23'h0000FF) && (expo > 8'd33)) ||
                          ((mant_d > 23'h00FFFF) && (expo > 8'd32)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q        <= neg_d;
    ovf_q        <= ovf_d;
    kill_q       <= kill_d;
    byte_shift_q <= byte_shift_d;
    mant_q       <= mant_d;
    hash_q       <= {item_i.hash_word3, item_i.hash_word2,
                     item_i.hash_word1, item_i.hash_word0};
  end

  assign ctl_o = '{valid: valid_q, negative: neg_q, overflow: ovf_q,
                   kill: kill_q, byte_shift: byte_shift_q};
  assign mant_o = mant_q;
  assign hash_o = hash_q;

endmodule

// ===== rtl/pwtc_shift.sv =====
// ----------------------------------------------------------------------------
// pwtc_shift
// Stage 2: place the mantissa into the 256-bit target by a byte shift, or clear it when killed.
// ----------------------------------------------------------------------------
module pwtc_shift
  import pwtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwtc_ctl_t          ctl_i,
  input  logic [MantW-1:0]   mant_i,
  input  logic [TargetW-1:0] hash_i,
  output pwtc_stat_t         stat_o,
  output logic [TargetW-1:0] target_o,
  output logic [TargetW-1:0] hash_o
);

  logic [TargetW-1:0] mant_wide;
  logic [TargetW-1:0] target_d;

  logic               valid_q;
  logic               neg_q;
  logic               ovf_q;
  logic [TargetW-1:0] target_q;
  logic [TargetW-1:0] hash_q;

  always_comb begin
    mant_wide = {{(TargetW-MantW){1'b0}}, mant_i};
    if (ctl_i.kill) begin
      target_d = '0;
    end else begin
      target_d = mant_wide << {ctl_i.byte_shift, 3'b000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= ctl_i.negative;
    ovf_q    <= ctl_i.overflow;
    target_q <= target_d;
    hash_q   <= hash_i;
  end

  assign stat_o   = '{valid: valid_q, negative: neg_q, overflow: ovf_q};
  assign target_o = target_q;
  assign hash_o   = hash_q;

endmodule

// ===== rtl/pwtc_compare.sv =====
// ----------------------------------------------------------------------------
// pwtc_compare
// Stages 3 and 4: word compares against limit and hash, then status resolve.
// ----------------------------------------------------------------------------
module pwtc_compare
  import pwtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwtc_stat_t         stat_i,
  input  logic [TargetW-1:0] target_i,
  input  logic [TargetW-1:0] hash_i,
  input  logic [TargetW-1:0] limit_i,
  output logic               done_o,
  output pwtc_out_t          result_o
);

  localparam int unsigned NumWords = TargetW / WordW;

  logic [NumWords-1:0] tl_gt_d, tl_eq_d, ht_gt_d, ht_eq_d;
  logic                zero_d;

  logic                valid_q;
  logic                neg_q;
  logic                ovf_q;
  logic                zero_q;
  logic [NumWords-1:0] tl_gt_q, tl_eq_q, ht_gt_q, ht_eq_q;

  logic                tgt_above;
  logic                hash_above;
  pwtc_out_t           result_d;

  logic                done_q;
  pwtc_out_t           result_q;

  function automatic logic gt_cascade(logic [3:0] gt, logic [3:0] eq);
    gt_cascade = gt[3] | (eq[3] & (gt[2] | (eq[2] & (gt[1] | (eq[1] & gt[0])))));
  endfunction

  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      tl_gt_d[i] = target_i[i*WordW +: WordW] >  limit_i[i*WordW +: WordW];
      tl_eq_d[i] = target_i[i*WordW +: WordW] == limit_i[i*WordW +: WordW];
      ht_gt_d[i] = hash_i[i*WordW +: WordW]   >  target_i[i*WordW +: WordW];
      ht_eq_d[i] = hash_i[i*WordW +: WordW]   == target_i[i*WordW +: WordW];
    end
    zero_d = (target_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= stat_i.valid;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= stat_i.negative;
    ovf_q    <= stat_i.overflow;
    zero_q   <= zero_d;
    tl_gt_q  <= tl_gt_d;
    tl_eq_q  <= tl_eq_d;
    ht_gt_q  <= ht_gt_d;
    ht_eq_q  <= ht_eq_d;
    result_q <= result_d;
  end

  always_comb begin
    tgt_above  = gt_cascade(tl_gt_q, tl_eq_q);
    hash_above = gt_cascade(ht_gt_q, ht_eq_q);
    result_d.negative_flag = neg_q;
    result_d.overflow_flag = ovf_q;
    if (neg_q || ovf_q || zero_q || tgt_above) begin
      result_d.status = STATUS_INVALID;
    end else if (hash_above) begin
      result_d.status = STATUS_ABOVE;
    end else begin
      result_d.status = STATUS_PASS;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== rtl/pow_target_check.sv =====
// ----------------------------------------------------------------------------
// pow_target_check
// Proof-of-work check of a 256-bit hash against a compact difficulty target.
// ----------------------------------------------------------------------------
// One item is accepted in every cycle (busy is always low) and its result
// appears on result_o with done_o high, in order. The four register stages
// are compact decode, byte shift of the mantissa into the target, per-word
// compares against limit and hash, and status resolve. Results cannot be
// held off and must be taken on the cycle done_o is high. The user must write
// limit words through cfg_we_i only while idle; the block does not enforce it.
module pow_target_check
  import pwtc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pwtc_in_t             item_i,
  output logic                 done_o,
  output pwtc_out_t            result_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [WordW-1:0]     cfg_data_i
);

  logic [3:0][WordW-1:0] limit_q;
  logic [3:0][WordW-1:0] limit_d;

  pwtc_ctl_t          dec_ctl;
  logic [MantW-1:0]   dec_mant;
  logic [TargetW-1:0] dec_hash;
  pwtc_stat_t         sh_stat;
  logic [TargetW-1:0] sh_target;
  logic [TargetW-1:0] sh_hash;

  assign busy = 1'b0;

  always_comb begin
    limit_d = limit_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LIMIT_WORD0: limit_d[0] = cfg_data_i;
        REG_LIMIT_WORD1: limit_d[1] = cfg_data_i;
        REG_LIMIT_WORD2: limit_d[2] = cfg_data_i;
        REG_LIMIT_WORD3: limit_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q[0] <= LIMIT_WORD0_RST;
      limit_q[1] <= LIMIT_WORD1_RST;
      limit_q[2] <= LIMIT_WORD2_RST;
      limit_q[3] <= LIMIT_WORD3_RST;
    end else begin
      limit_q <= limit_d;
    end
  end

  pwtc_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .item_i  (item_i),
    .ctl_o   (dec_ctl),
    .mant_o  (dec_mant),
    .hash_o  (dec_hash)
  );

  pwtc_shift u_shift (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (dec_ctl),
    .mant_i   (dec_mant),
    .hash_i   (dec_hash),
    .stat_o   (sh_stat),
    .target_o (sh_target),
    .hash_o   (sh_hash)
  );

  pwtc_compare u_compare (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stat_i   (sh_stat),
    .target_i (sh_target),
    .hash_i   (sh_hash),
    .limit_i  (limit_q),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
